// ===== src/bvo_pkg.sv =====
// shared constants, types and helper functions of the broadcast view offset unit
package bvo_pkg;

	localparam int RANK      = 4;
	localparam int POS_W     = 12;
	localparam int DIM_W     = POS_W + 1;
	localparam int LIN_W     = 48;
	localparam int PROD_W    = RANK * DIM_W;
	localparam int REG_IDX_W = 3;
	localparam int DIGIT_W   = 4;
	localparam int REM_W     = POS_W;

	localparam logic [DIM_W-1:0] DIM_ONE   = DIM_W'(1);
	localparam logic [DIM_W-1:0] DIM_LIMIT = DIM_W'(1) << POS_W;

	localparam logic [REG_IDX_W-1:0] REG_SRC_DIM_0  = REG_IDX_W'(0);
	localparam logic [REG_IDX_W-1:0] REG_VIEW_DIM_0 = REG_IDX_W'(RANK);

	localparam logic [1:0] ERR_OK    = 2'd0;
	localparam logic [1:0] ERR_SHAPE = 2'd1;
	localparam logic [1:0] ERR_RANGE = 2'd2;

	typedef logic [RANK-1:0][DIM_W-1:0] dims_t;

	typedef struct packed {
		logic                       linear;
		logic [1:0]                 err;
		logic [LIN_W-1:0]           lp;
		logic [PROD_W-1:0]          prod;
		logic [REM_W-1:0]           rem;
		logic [LIN_W-1:0]           num;
		logic [LIN_W-1:0]           quo;
		logic [RANK-1:0][POS_W-1:0] idx;
		logic [LIN_W-1:0]           acc;
	} stage_t;

	function automatic logic shapes_ok(dims_t src, dims_t view);
		logic ok;
		ok = 1'b1;
		for (int i = 0; i < RANK; i++) begin
			if (src[i] == '0 || view[i] == '0 || src[i] > DIM_LIMIT || view[i] > DIM_LIMIT)
				ok = 1'b0;
			if (src[i] != DIM_ONE && src[i] != view[i])
				ok = 1'b0;
		end
		return ok;
	endfunction

	// four restoring division steps: returns {remainder, quotient digit}
	function automatic logic [REM_W+DIGIT_W-1:0] div_digit(logic [REM_W-1:0] rem,
			logic [DIGIT_W-1:0] bits, logic [DIM_W-1:0] dv);
		logic [DIM_W-1:0]   r;
		logic [DIGIT_W-1:0] q;
		r = {1'b0, rem};
		q = '0;
		for (int i = DIGIT_W - 1; i >= 0; i--) begin
			r = {r[DIM_W-2:0], bits[i]};
			if (r >= dv) begin
				r    = r - dv;
				q[i] = 1'b1;
			end
		end
		return {r[REM_W-1:0], q};
	endfunction

	// broadcast dimensions contribute nothing
	function automatic logic [POS_W-1:0] bcast_idx(logic [POS_W-1:0] idx, logic [DIM_W-1:0] s);
		return (s == DIM_ONE) ? '0 : idx;
	endfunction

endpackage

// ===== src/bvo_if.sv =====
// request and result channel interfaces
interface bvo_req_if import bvo_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             action;
	logic [POS_W-1:0] pos_0;
	logic [POS_W-1:0] pos_1;
	logic [POS_W-1:0] pos_2;
	logic [POS_W-1:0] pos_3;
	logic [LIN_W-1:0] linear_pos;

	modport source (output valid, action, pos_0, pos_1, pos_2, pos_3, linear_pos, input ready);
	modport sink (input valid, action, pos_0, pos_1, pos_2, pos_3, linear_pos, output ready);
endinterface

interface bvo_rsp_if import bvo_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [LIN_W-1:0] offset;
	logic [1:0]       error;

	modport source (output valid, offset, error, input ready);
	modport sink (input valid, offset, error, output ready);
endinterface

// ===== src/broadcast_view_offset_unit.sv =====
// broadcast view offset unit: pipelined view position to source offset mapper
//
// Takes one transaction per cycle while the output is not stalled and returns
// one result per transaction, in order. The pipeline depth is set by the split
// of the linear index into view digits: three chained long divisions by the view
// sizes, four quotient bits per pipeline stage, followed by three multiply-add
// stages that form the source offset. Multi-index transactions travel the same
// pipeline. A stage holds its transaction while the next is full and stalled, so
// bubbles are squeezed out under back-pressure. The user must write the shape
// registers through cfg only while no transaction is in flight (not enforced).
module broadcast_view_offset_unit import bvo_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [DIM_W-1:0]     cfg_data,
	bvo_req_if.sink              req,
	bvo_rsp_if.source            rsp
);

	localparam int DIV0_N = LIN_W / DIGIT_W;
	localparam int DIV1_N = (LIN_W - POS_W) / DIGIT_W;
	localparam int DIV2_N = (LIN_W - 2 * POS_W) / DIGIT_W;
	localparam int DIV_N  = DIV0_N + DIV1_N + DIV2_N;
	localparam int NST    = 1 + DIV_N + 3;

	dims_t src_dim_q;
	dims_t view_dim_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < RANK; i++) begin
				src_dim_q[i]  <= DIM_ONE;
				view_dim_q[i] <= DIM_ONE;
			end
		end else if (cfg_we) begin
			if (cfg_index < REG_VIEW_DIM_0)
				src_dim_q[cfg_index[1:0] - REG_SRC_DIM_0[1:0]] <= cfg_data;
			else
				view_dim_q[cfg_index[1:0] - REG_VIEW_DIM_0[1:0]] <= cfg_data;
		end
	end

	logic   shape_ok;
	assign shape_ok = shapes_ok(src_dim_q, view_dim_q);

	stage_t           stg_s [NST];
	stage_t           nxt   [NST];
	logic [NST-1:0]   vld_s;
	logic [NST-1:0]   vld_in;
	logic [NST:0]     adv;

	assign adv[NST] = rsp.ready;
	assign req.ready = adv[0];
	assign vld_in[0] = req.valid;

	// entry stage: mode, shape and multi-index range checks
	always_comb begin
		nxt[0]        = '0;
		nxt[0].linear = req.action;
		nxt[0].lp     = req.linear_pos;
		nxt[0].num    = req.linear_pos;
		nxt[0].idx    = {req.pos_3, req.pos_2, req.pos_1, req.pos_0};
		nxt[0].prod   = PROD_W'({{DIM_W{1'b0}}, view_dim_q[0]}
				* {{DIM_W{1'b0}}, view_dim_q[1]});
		if (!shape_ok)
			nxt[0].err = ERR_SHAPE;
		else if (!req.action && ({1'b0, req.pos_0} >= view_dim_q[0]
				|| {1'b0, req.pos_1} >= view_dim_q[1]
				|| {1'b0, req.pos_2} >= view_dim_q[2]
				|| {1'b0, req.pos_3} >= view_dim_q[3]))
			nxt[0].err = ERR_RANGE;
		else
			nxt[0].err = ERR_OK;
	end

	genvar k;
	generate
		for (k = 1; k < NST; k++) begin : g_stage
			assign vld_in[k] = vld_s[k-1];

			if (k <= DIV_N) begin : g_div
				localparam int J    = k - 1;
				localparam int D    = (J < DIV0_N) ? 0 : ((J < DIV0_N + DIV1_N) ? 1 : 2);
				localparam bit LAST = (J == DIV0_N - 1) || (J == DIV0_N + DIV1_N - 1)
						|| (J == DIV_N - 1);
				logic [REM_W+DIGIT_W-1:0] dq;
				logic [LIN_W-1:0]         quo_n;

				assign dq    = div_digit(stg_s[k-1].rem, stg_s[k-1].num[LIN_W-1 -: DIGIT_W],
						view_dim_q[RANK-1-D]);
				assign quo_n = {stg_s[k-1].quo[LIN_W-DIGIT_W-1:0], dq[DIGIT_W-1:0]};

				always_comb begin
					nxt[k]      = stg_s[k-1];
					nxt[k].rem  = dq[REM_W+DIGIT_W-1:DIGIT_W];
					nxt[k].num  = {stg_s[k-1].num[LIN_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
					nxt[k].quo  = quo_n;
					// total view size builds up alongside the first digits
					if (J == 0)
						nxt[k].prod = PROD_W'({{DIM_W{1'b0}}, stg_s[k-1].prod[2*DIM_W-1:0]}
								* {{(2*DIM_W){1'b0}}, view_dim_q[2]});
					if (J == 1)
						nxt[k].prod = {{DIM_W{1'b0}}, stg_s[k-1].prod[3*DIM_W-1:0]}
								* {{(3*DIM_W){1'b0}}, view_dim_q[3]};
					if (J == 2 && stg_s[k-1].linear && stg_s[k-1].err == ERR_OK
							&& {{(PROD_W-LIN_W){1'b0}}, stg_s[k-1].lp} >= stg_s[k-1].prod)
						nxt[k].err = ERR_RANGE;
					if (LAST) begin
						nxt[k].num = quo_n << (POS_W * (D + 1));
						nxt[k].quo = '0;
						nxt[k].rem = '0;
						if (stg_s[k-1].linear) begin
							nxt[k].idx[RANK-1-D] = dq[REM_W+DIGIT_W-1:DIGIT_W];
							if (D == 2)
								nxt[k].idx[0] = quo_n[POS_W-1:0];
						end
					end
				end
			end else if (k == DIV_N + 1) begin : g_mac0
				always_comb begin
					nxt[k]     = stg_s[k-1];
					nxt[k].acc = LIN_W'({{DIM_W{1'b0}}, bcast_idx(stg_s[k-1].idx[0], src_dim_q[0])}
							* {{POS_W{1'b0}}, src_dim_q[1]})
							+ LIN_W'(bcast_idx(stg_s[k-1].idx[1], src_dim_q[1]));
				end
			end else if (k == DIV_N + 2) begin : g_mac1
				always_comb begin
					nxt[k]     = stg_s[k-1];
					nxt[k].acc = LIN_W'({{DIM_W{1'b0}}, stg_s[k-1].acc[2*DIM_W-1:0]}
							* {{(2*DIM_W){1'b0}}, src_dim_q[2]})
							+ LIN_W'(bcast_idx(stg_s[k-1].idx[2], src_dim_q[2]));
				end
			end else begin : g_mac2
				logic [4*DIM_W-1:0] sum;
				assign sum = {{DIM_W{1'b0}}, stg_s[k-1].acc[3*DIM_W-1:0]}
						* {{(3*DIM_W){1'b0}}, src_dim_q[3]};
				always_comb begin
					nxt[k]     = stg_s[k-1];
					nxt[k].acc = (stg_s[k-1].err != ERR_OK) ? '0
							: sum[LIN_W-1:0]
							+ LIN_W'(bcast_idx(stg_s[k-1].idx[3], src_dim_q[3]));
				end
			end
		end

		for (k = 0; k < NST; k++) begin : g_reg
			assign adv[k] = !vld_s[k] || adv[k+1];

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n)
					vld_s[k] <= 1'b0;
				else if (adv[k])
					vld_s[k] <= vld_in[k];
			end

			always_ff @(posedge clk) begin
				if (adv[k] && vld_in[k])
					stg_s[k] <= nxt[k];
			end
		end
	endgenerate

	assign rsp.valid  = vld_s[NST-1];
	assign rsp.offset = stg_s[NST-1].acc;
	assign rsp.error  = stg_s[NST-1].err;

`ifndef ASSERT_OFF
	a_err_zero_offset: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.error != ERR_OK |-> rsp.offset == '0)
		else $error("offset not cleared on an error result");

	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> rsp.error == ERR_OK || rsp.error == ERR_SHAPE || rsp.error == ERR_RANGE)
		else $error("undefined error code");

	a_full_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		!req.ready |-> &vld_s && !rsp.ready)
		else $error("request blocked with room in the pipeline");

	a_shape_flag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.error == ERR_SHAPE |-> !shape_ok)
		else $error("shape error with consistent shapes");
`endif

endmodule
